// ===== sv/dvru_pkg.sv =====
// shared types and constants of the distance-vector route update unit
`default_nettype none

package dvru_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned COST_W      = 5;
  localparam int unsigned PLUS_W      = COST_W + 1;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned ACTION_W    = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned IFCNT_W     = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [COST_W-1:0]  COST_INF    = 5'd16;
  localparam logic [COST_W-1:0]  COST_ONE    = 5'd1;
  localparam logic [IFCNT_W-1:0] MAX_IFACES  = 3'd4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERTED  = 3'd0,
    ACT_IMPROVED  = 3'd1,
    ACT_UNCHANGED = 3'd2,
    ACT_OWN       = 3'd3,
    ACT_FULL      = 3'd4
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADDR_A = 3'd0,
    CFG_ADDR_B = 3'd1,
    CFG_ADDR_C = 3'd2,
    CFG_ADDR_D = 3'd3,
    CFG_COUNT  = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } back_state_e;

  typedef struct packed {
    logic              own;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] sender;
    logic [ADDR_W-1:0] recv;
    logic [PLUS_W-1:0] plus_one;
    logic [COST_W-1:0] capped;
    logic [COST_W-1:0] ins_cost;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    action_e           action;
    logic [COST_W-1:0] cost;
    logic [ADDR_W-1:0] next_hop;
    logic [ADDR_W-1:0] out_iface;
  } res_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [COST_W-1:0] cost;
    logic [ADDR_W-1:0] next_hop;
    logic [ADDR_W-1:0] iface;
  } entry_t;

endpackage

`default_nettype wire

// ===== sv/dvru_queue.sv =====
// small word queue used between the front, the back and the result ports
`default_nettype none

module dvru_queue #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);
  import dvru_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [Width-1:0] store_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dvru_front.sv =====
// front end: own-interface registers and classification of incoming routes
`default_nettype none

module dvru_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [dvru_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [dvru_pkg::ADDR_W-1:0]      cfg_data_i,
  input  wire logic [dvru_pkg::ADDR_W-1:0]      dest_addr_i,
  input  wire logic [dvru_pkg::COST_W-1:0]      adv_cost_i,
  input  wire logic [dvru_pkg::ADDR_W-1:0]      sender_addr_i,
  input  wire logic [dvru_pkg::ADDR_W-1:0]      recv_iface_addr_i,
  output dvru_pkg::cmd_t                        cmd_o
);
  import dvru_pkg::*;

  logic [ADDR_W-1:0]  addr_a_q, addr_b_q, addr_c_q, addr_d_q;
  logic [IFCNT_W-1:0] if_count_q;
  logic [IFCNT_W-1:0] if_used;
  logic [PLUS_W-1:0]  plus_one;
  logic [COST_W-1:0]  capped;
  logic               own_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_a_q   <= '0;
      addr_b_q   <= '0;
      addr_c_q   <= '0;
      addr_d_q   <= '0;
      if_count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ADDR_A: addr_a_q   <= cfg_data_i;
        CFG_ADDR_B: addr_b_q   <= cfg_data_i;
        CFG_ADDR_C: addr_c_q   <= cfg_data_i;
        CFG_ADDR_D: addr_d_q   <= cfg_data_i;
        CFG_COUNT:  if_count_q <= cfg_data_i[IFCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // count above four acts as four
  assign if_used = (if_count_q > MAX_IFACES) ? MAX_IFACES : if_count_q;

  assign own_hit = ((if_used > 3'd0) && (dest_addr_i == addr_a_q))
                || ((if_used > 3'd1) && (dest_addr_i == addr_b_q))
                || ((if_used > 3'd2) && (dest_addr_i == addr_c_q))
                || ((if_used > 3'd3) && (dest_addr_i == addr_d_q));

  assign plus_one = {1'b0, adv_cost_i} + PLUS_W'(1);
  assign capped   = (plus_one > {1'b0, COST_INF}) ? COST_INF : plus_one[COST_W-1:0];

  always_comb begin
    cmd_o.own      = own_hit;
    cmd_o.dest     = dest_addr_i;
    cmd_o.sender   = sender_addr_i;
    cmd_o.recv     = recv_iface_addr_i;
    cmd_o.plus_one = plus_one;
    cmd_o.capped   = capped;
    cmd_o.ins_cost = (sender_addr_i == dest_addr_i) ? COST_ONE : capped;
  end

endmodule

`default_nettype wire

// ===== sv/dvru_back.sv =====
// back end: route table memory, sequential lookup, update and insert
`default_nettype none

module dvru_back #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire dvru_pkg::cmd_t cmd_i,
  input  wire logic    cmd_empty_i,
  output logic         cmd_pop_o,
  input  wire logic    res_full_i,
  output logic         res_push_o,
  output dvru_pkg::res_t res_o
);
  import dvru_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  entry_t          mem [TABLE_DEPTH];
  entry_t          rd_q;
  back_state_e     state_q, state_d;
  cmd_t            cmd_q, cmd_d, cur;
  logic [IdxW-1:0] idx_q, idx_d, raddr, waddr;
  logic [CntW-1:0] used_q, used_d;
  logic            we;
  entry_t          wdata;
  logic            start, hit, last, tbl_full, better;

  assign start    = !cmd_empty_i && !res_full_i;
  assign cur      = (state_q == BK_IDLE) ? cmd_i : cmd_q;
  assign hit      = (rd_q.dest == cmd_q.dest);
  assign last     = ((CntW'(idx_q) + CntW'(1)) == used_q);
  assign tbl_full = (used_q == CntW'(TABLE_DEPTH));
  assign better   = ({1'b0, rd_q.cost} > cmd_q.plus_one);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (start && !cmd_i.own && (used_q != '0)) begin
          state_d = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (hit || last) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    we         = 1'b0;
    waddr      = IdxW'(used_q);
    wdata      = '0;
    raddr      = idx_q + 1'b1;
    idx_d      = idx_q;
    used_d     = used_q;
    cmd_d      = cmd_q;
    case (state_q)
      BK_IDLE: begin
        raddr = '0;
        idx_d = '0;
        if (start) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
        end
      end
      BK_SCAN: begin
        if (hit) begin
          res_push_o      = 1'b1;
          res_o.slot      = SLOT_W'(idx_q);
          res_o.out_iface = rd_q.iface;
          if (better) begin
            we             = 1'b1;
            waddr          = idx_q;
            wdata          = rd_q;
            wdata.cost     = cmd_q.capped;
            wdata.next_hop = cmd_q.sender;
            res_o.action   = ACT_IMPROVED;
            res_o.cost     = cmd_q.capped;
            res_o.next_hop = cmd_q.sender;
          end else begin
            res_o.action   = ACT_UNCHANGED;
            res_o.cost     = rd_q.cost;
            res_o.next_hop = rd_q.next_hop;
          end
        end
      end
      default: ;
    endcase

    // own interface, or a miss against the whole filled table
    if ((state_q == BK_IDLE) && start && cmd_i.own) begin
      res_push_o      = 1'b1;
      res_o.action    = ACT_OWN;
      res_o.next_hop  = cmd_i.dest;
      res_o.out_iface = cmd_i.dest;
    end else if (((state_q == BK_IDLE) && start && (used_q == '0))
              || ((state_q == BK_SCAN) && !hit && last)) begin
      res_push_o = 1'b1;
      if (tbl_full) begin
        res_o.action = ACT_FULL;
        res_o.cost   = COST_INF;
      end else begin
        we              = 1'b1;
        waddr           = IdxW'(used_q);
        wdata.dest      = cur.dest;
        wdata.cost      = cur.ins_cost;
        wdata.next_hop  = cur.sender;
        wdata.iface     = cur.recv;
        used_d          = used_q + 1'b1;
        res_o.slot      = SLOT_W'(used_q);
        res_o.action    = ACT_INSERTED;
        res_o.cost      = cur.ins_cost;
        res_o.next_hop  = cur.sender;
        res_o.out_iface = cur.recv;
      end
    end

    if ((state_q == BK_SCAN) && !hit && !last) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      used_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> (used_q == $past(used_q) + CntW'(1)))
    else $error("fill count moved by more than one");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SCAN) |-> (CntW'(idx_q) < used_q))
    else $error("scan index past filled slots");

  a_write_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> res_push_o)
    else $error("table written without a result word");

endmodule

`default_nettype wire

// ===== sv/distance_vector_route_update_unit.sv =====
// top level of the distance-vector route update unit
//
// Each accepted route enters a two-word command queue and is then handled by a
// table engine that reads the route memory through its single read port, one
// stored slot per cycle. An own-interface route, or any route while the table
// is empty, is handled by the engine in its idle state; otherwise the engine
// leaves idle and scans the filled slots in order up to a hit or the last
// one, and the word shows on the result side the cycle after the engine
// finishes. The table needs no clearing pass: slots are filled in order and
// a fill count marks which are valid. Slot numbers are reported modulo 64.
`default_nettype none

module distance_vector_route_update_unit #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [dvru_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [dvru_pkg::ADDR_W-1:0]      cfg_data_i,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [dvru_pkg::ADDR_W-1:0]      dest_addr_i,
  input  wire logic [dvru_pkg::COST_W-1:0]      adv_cost_i,
  input  wire logic [dvru_pkg::ADDR_W-1:0]      sender_addr_i,
  input  wire logic [dvru_pkg::ADDR_W-1:0]      recv_iface_addr_i,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic [dvru_pkg::SLOT_W-1:0]           entry_slot_o,
  output logic [dvru_pkg::ACTION_W-1:0]         action_o,
  output logic [dvru_pkg::COST_W-1:0]           entry_cost_o,
  output logic [dvru_pkg::ADDR_W-1:0]           entry_next_hop_o,
  output logic [dvru_pkg::ADDR_W-1:0]           entry_out_iface_o
);
  import dvru_pkg::*;

  cmd_t front_cmd, head_cmd;
  res_t back_res, out_res;
  logic cmd_empty, cmd_pop, res_full, res_push;

  dvru_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .dest_addr_i       (dest_addr_i),
    .adv_cost_i        (adv_cost_i),
    .sender_addr_i     (sender_addr_i),
    .recv_iface_addr_i (recv_iface_addr_i),
    .cmd_o             (front_cmd)
  );

  dvru_queue #(
    .Width ($bits(cmd_t))
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (head_cmd),
    .empty_o (cmd_empty)
  );

  dvru_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  dvru_queue #(
    .Width ($bits(res_t))
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign entry_slot_o      = out_res.slot;
  assign action_o          = out_res.action;
  assign entry_cost_o      = out_res.cost;
  assign entry_next_hop_o  = out_res.next_hop;
  assign entry_out_iface_o = out_res.out_iface;

endmodule

`default_nettype wire

// ===== bench/distance_vector_route_update_unit_tb.sv =====
// self-checking testbench of the distance-vector route update unit
`timescale 1ns / 100ps

module distance_vector_route_update_unit_tb;
  import dvru_pkg::*;

  localparam int ROUTE_SLOTS = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_WORDS = 128;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST = 3'd7;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [ADDR_W-1:0]    data;
    logic [ADDR_W-1:0]    dest;
    logic [COST_W-1:0]    cost;
    logic [ADDR_W-1:0]    sender;
    logic [ADDR_W-1:0]    recv;
    logic                 typed;
    res_t                 want;
  } plan_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [ADDR_W-1:0]    cfg_data_i = '0;
  logic                 push = 1'b0;
  logic                 full;
  logic [ADDR_W-1:0]    dest_addr_i = '0;
  logic [COST_W-1:0]    adv_cost_i = '0;
  logic [ADDR_W-1:0]    sender_addr_i = '0;
  logic [ADDR_W-1:0]    recv_iface_addr_i = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [SLOT_W-1:0]    entry_slot_o;
  logic [ACTION_W-1:0]  action_o;
  logic [COST_W-1:0]    entry_cost_o;
  logic [ADDR_W-1:0]    entry_next_hop_o;
  logic [ADDR_W-1:0]    entry_out_iface_o;

  // route table mirror and register copies
  logic [ADDR_W-1:0]  tbl_dest [ROUTE_SLOTS];
  logic [COST_W-1:0]  tbl_cost [ROUTE_SLOTS];
  logic [ADDR_W-1:0]  tbl_hop [ROUTE_SLOTS];
  logic [ADDR_W-1:0]  tbl_iface [ROUTE_SLOTS];
  int                 route_cnt = 0;
  logic [ADDR_W-1:0]  own_addr [4] = '{default: '0};
  logic [IFCNT_W-1:0] own_cnt = '0;

  res_t      pending_entries[$];
  plan_row_t plan_rows[$];
  int        bad_entries = 0;
  int        stall_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  distance_vector_route_update_unit #(
    .TABLE_DEPTH(ROUTE_SLOTS)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .push              (push),
    .full              (full),
    .dest_addr_i       (dest_addr_i),
    .adv_cost_i        (adv_cost_i),
    .sender_addr_i     (sender_addr_i),
    .recv_iface_addr_i (recv_iface_addr_i),
    .empty             (empty),
    .pop               (pop),
    .entry_slot_o      (entry_slot_o),
    .action_o          (action_o),
    .entry_cost_o      (entry_cost_o),
    .entry_next_hop_o  (entry_next_hop_o),
    .entry_out_iface_o (entry_out_iface_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic res_t mk_res(input logic [SLOT_W-1:0] slot, input action_e act,
                                  input logic [COST_W-1:0] cost,
                                  input logic [ADDR_W-1:0] hop,
                                  input logic [ADDR_W-1:0] iface);
    res_t r;
    r.slot = slot;
    r.action = act;
    r.cost = cost;
    r.next_hop = hop;
    r.out_iface = iface;
    return r;
  endfunction

  function automatic res_t route_update(input logic [ADDR_W-1:0] dest,
                                        input logic [COST_W-1:0] adv,
                                        input logic [ADDR_W-1:0] from,
                                        input logic [ADDR_W-1:0] recv);
    res_t r;
    logic [PLUS_W-1:0] plus_one;
    logic [COST_W-1:0] capped;
    logic is_own;
    int n;
    int k;
    int hit;
    plus_one = PLUS_W'(adv) + PLUS_W'(1);
    capped = (plus_one > PLUS_W'(COST_INF)) ? COST_INF : plus_one[COST_W-1:0];
    n = (own_cnt > MAX_IFACES) ? 4 : int'(own_cnt);
    is_own = 1'b0;
    for (k = 0; k < n; k++)
      if (own_addr[k] == dest) is_own = 1'b1;
    hit = -1;
    for (k = 0; k < route_cnt; k++)
      if (hit < 0 && tbl_dest[k] == dest) hit = k;
    if (is_own) begin
      r = mk_res('0, ACT_OWN, '0, dest, dest);
    end else if (hit >= 0) begin
      if (PLUS_W'(tbl_cost[hit]) > plus_one) begin
        tbl_cost[hit] = capped;
        tbl_hop[hit] = from;
        r = mk_res(SLOT_W'(hit), ACT_IMPROVED, tbl_cost[hit], tbl_hop[hit], tbl_iface[hit]);
      end else begin
        r = mk_res(SLOT_W'(hit), ACT_UNCHANGED, tbl_cost[hit], tbl_hop[hit],
                   tbl_iface[hit]);
      end
    end else if (route_cnt >= ROUTE_SLOTS) begin
      r = mk_res('0, ACT_FULL, COST_INF, '0, '0);
    end else begin
      tbl_dest[route_cnt] = dest;
      tbl_iface[route_cnt] = recv;
      tbl_hop[route_cnt] = from;
      tbl_cost[route_cnt] = (from == dest) ? COST_ONE : capped;
      r = mk_res(SLOT_W'(route_cnt), ACT_INSERTED, tbl_cost[route_cnt], from, recv);
      route_cnt++;
    end
    return r;
  endfunction

  task automatic plan_route(input logic [ADDR_W-1:0] dest, input logic [COST_W-1:0] cost,
                            input logic [ADDR_W-1:0] sender, input logic [ADDR_W-1:0] recv,
                            input logic typed, input res_t want);
    plan_row_t row;
    row = '0;
    row.dest = dest;
    row.cost = cost;
    row.sender = sender;
    row.recv = recv;
    row.typed = typed;
    row.want = want;
    plan_rows = {plan_rows, row};
  endtask

  task automatic plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    plan_rows = {plan_rows, row};
  endtask

  // write enable is left high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_ADDR_A: own_addr[0] = data;
      CFG_ADDR_B: own_addr[1] = data;
      CFG_ADDR_C: own_addr[2] = data;
      CFG_ADDR_D: own_addr[3] = data;
      CFG_COUNT:  own_cnt = data[IFCNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    push <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_route(input logic [ADDR_W-1:0] dest, input logic [COST_W-1:0] cost,
                            input logic [ADDR_W-1:0] sender, input logic [ADDR_W-1:0] recv,
                            input logic typed, input res_t want);
    res_t predicted;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk_i);
    end
    push <= 1'b1;
    dest_addr_i <= dest;
    adv_cost_i <= cost;
    sender_addr_i <= sender;
    recv_iface_addr_i <= recv;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predicted = route_update(dest, cost, sender, recv);
    pending_entries = {pending_entries, (typed ? want : predicted)};
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40 && route_cnt > 0) return tbl_dest[$urandom_range(0, route_cnt - 1)];
    if (pick < 50) return '0;
    if (pick < 60) return '1;
    return $urandom;
  endfunction

  task automatic pick_config(input int sub);
    logic [ADDR_W-1:0] cnt_word;
    settle();
    write_reg(CFG_ADDR_A, pick_addr());
    write_reg(CFG_ADDR_B, pick_addr());
    write_reg(CFG_ADDR_C, pick_addr());
    write_reg(CFG_ADDR_D, pick_addr());
    cnt_word = $urandom;
    case (sub)
      0: cnt_word[IFCNT_W-1:0] = MAX_IFACES;
      4: cnt_word[IFCNT_W-1:0] = '0;
      8: cnt_word[IFCNT_W-1:0] = '1;
      default: ;
    endcase
    write_reg(CFG_COUNT, cnt_word);
    write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), $urandom);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_route();
    logic [ADDR_W-1:0] d;
    logic [ADDR_W-1:0] s;
    logic [ADDR_W-1:0] r;
    logic [COST_W-1:0] c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) d = own_addr[$urandom_range(0, 3)];
    else if (pick < 22 || route_cnt == 0) d = $urandom;
    else d = tbl_dest[$urandom_range(0, route_cnt - 1)];
    c = ($urandom_range(0, 99) < 85) ? COST_W'($urandom_range(0, 16))
                                     : COST_W'($urandom_range(17, 31));
    s = ($urandom_range(0, 99) < 15) ? d : $urandom;
    r = ($urandom_range(0, 99) < 50) ? own_addr[$urandom_range(0, 3)] : $urandom;
    send_route(d, c, s, r, 1'b0, '0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_entries.size() == 0) begin
        if (bad_entries < 10)
          $display("unexpected word: slot %0d action %0d cost %0d hop %h iface %h",
                   entry_slot_o, action_o, entry_cost_o, entry_next_hop_o,
                   entry_out_iface_o);
        bad_entries++;
      end else begin
        want = pending_entries.pop_front();
        if (entry_slot_o !== want.slot || action_o !== want.action ||
            entry_cost_o !== want.cost || entry_next_hop_o !== want.next_hop ||
            entry_out_iface_o !== want.out_iface) begin
          if (bad_entries < 10)
            $display({"word mismatch (expected/actual): slot %0d/%0d action %0d/%0d",
                      " cost %0d/%0d hop %h/%h iface %h/%h"},
                     want.slot, entry_slot_o, want.action, action_o, want.cost,
                     entry_cost_o, want.next_hop, entry_next_hop_o, want.out_iface,
                     entry_out_iface_o);
          bad_entries++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    plan_route(32'h0, 5'd0, 32'h0, 32'h0, 1'b1,
               mk_res(6'd0, ACT_INSERTED, 5'd1, 32'h0, 32'h0));
    plan_route(32'hFFFFFFFF, 5'd31, 32'hFFFFFFFE, 32'hFFFFFFFF, 1'b1,
               mk_res(6'd1, ACT_INSERTED, 5'd16, 32'hFFFFFFFE, 32'hFFFFFFFF));
    plan_route(32'hFFFFFFFF, 5'd16, 32'h1, 32'h0, 1'b1,
               mk_res(6'd1, ACT_UNCHANGED, 5'd16, 32'hFFFFFFFE, 32'hFFFFFFFF));
    plan_route(32'hFFFFFFFF, 5'd0, 32'h12345678, 32'hAAAAAAAA, 1'b1,
               mk_res(6'd1, ACT_IMPROVED, 5'd1, 32'h12345678, 32'hFFFFFFFF));
    plan_route(32'h0, 5'd0, 32'h5, 32'h0, 1'b1,
               mk_res(6'd0, ACT_UNCHANGED, 5'd1, 32'h0, 32'h0));
    plan_route(32'h0A000001, 5'd15, 32'h0A000002, 32'h55555555, 1'b1,
               mk_res(6'd2, ACT_INSERTED, 5'd16, 32'h0A000002, 32'h55555555));
    plan_route(32'h0A000001, 5'd14, 32'h0A000003, 32'h0, 1'b1,
               mk_res(6'd2, ACT_IMPROVED, 5'd15, 32'h0A000003, 32'h55555555));
    plan_route(32'h0A000001, 5'd16, 32'h0A000004, 32'h0, 1'b1,
               mk_res(6'd2, ACT_UNCHANGED, 5'd15, 32'h0A000003, 32'h55555555));
    plan_route(32'hC0A80001, 5'd3, 32'hC0A80001, 32'h0F0F0F0F, 1'b1,
               mk_res(6'd3, ACT_INSERTED, 5'd1, 32'hC0A80001, 32'h0F0F0F0F));
    plan_route(32'h80000000, 5'd1, 32'h7FFFFFFF, 32'hF0F0F0F0, 1'b0, '0);
    plan_route(32'h80000000, 5'd0, 32'h1, 32'h0, 1'b0, '0);
    plan_route(32'h80000000, 5'd17, 32'h2, 32'h0, 1'b0, '0);
    plan_cfg(CFG_ADDR_A, 32'h0A000001);
    plan_cfg(CFG_ADDR_B, 32'hFFFFFFFF);
    plan_cfg(CFG_ADDR_C, 32'h0);
    plan_cfg(CFG_ADDR_D, 32'hC0A80001);
    plan_cfg(CFG_COUNT, 32'd2);
    plan_route(32'h0A000001, 5'd5, 32'h1, 32'h2, 1'b1,
               mk_res(6'd0, ACT_OWN, 5'd0, 32'h0A000001, 32'h0A000001));
    plan_route(32'hFFFFFFFF, 5'd0, 32'h1, 32'h2, 1'b1,
               mk_res(6'd0, ACT_OWN, 5'd0, 32'hFFFFFFFF, 32'hFFFFFFFF));
    plan_route(32'h0, 5'd5, 32'h1, 32'h2, 1'b1,
               mk_res(6'd0, ACT_UNCHANGED, 5'd1, 32'h0, 32'h0));
    plan_route(32'hC0A80001, 5'd0, 32'h1, 32'h2, 1'b0, '0);
    // count above four, then writes to unused indexes that must not land
    plan_cfg(CFG_COUNT, 32'hFFFFFFFF);
    plan_cfg(CFG_SPARE_FIRST, 32'h0);
    plan_cfg(CFG_IDX_W'(6), 32'h0);
    plan_cfg(CFG_SPARE_LAST, 32'h0);
    plan_route(32'h0, 5'd0, 32'h1, 32'h2, 1'b1,
               mk_res(6'd0, ACT_OWN, 5'd0, 32'h0, 32'h0));
    plan_route(32'hC0A80001, 5'd20, 32'h1, 32'h2, 1'b1,
               mk_res(6'd0, ACT_OWN, 5'd0, 32'hC0A80001, 32'hC0A80001));
    plan_cfg(CFG_COUNT, 32'd0);
    plan_route(32'h0A000001, 5'd20, 32'h9, 32'h9, 1'b1,
               mk_res(6'd2, ACT_UNCHANGED, 5'd15, 32'h0A000003, 32'h55555555));
    plan_route(32'h0A000001, 5'd0, 32'h0A000009, 32'h9, 1'b0, '0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 28;
    recv_idle_pct = 72;
    foreach (plan_rows[i]) begin
      if (plan_rows[i].is_cfg) begin
        if (!cfg_we_i) settle();
        write_reg(plan_rows[i].idx, plan_rows[i].data);
      end else begin
        if (cfg_we_i) cfg_we_i <= 1'b0;
        send_route(plan_rows[i].dest, plan_rows[i].cost, plan_rows[i].sender,
                   plan_rows[i].recv, plan_rows[i].typed, plan_rows[i].want);
      end
    end

    for (int sub = 0; sub < 9; sub++) begin
      pick_config(sub);
      case (sub / 3)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 72;
        end
        1: begin
          send_idle_pct = 72;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (PHASE_WORDS) random_route();
    end

    push <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk_i);
    repeat (ROUTE_SLOTS + 16) @(posedge clk_i);
    if (bad_entries == 0 && pending_entries.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
